>>> hw/rtl/slms_pkg.sv
// Shared constants, codes and types for the scrolling LED matrix scan driver.
// No dependencies; slms_fbuf and scrolling_led_matrix_scan import this package.
package slms_pkg;

  localparam int SHOWN_COLUMNS = 4;
  localparam int BUF_COLS      = 256;
  localparam int BUF_ROWS      = 16;

  localparam int COL_W = $clog2(BUF_COLS);
  localparam int ROW_W = $clog2(BUF_ROWS);
  localparam int LEN_W = 9;
  localparam int CC_W  = $clog2(SHOWN_COLUMNS + 1);

  localparam logic [7:0]  TEXT_LENGTH_RST       = 8'd0;
  localparam logic [7:0]  BLANK_LENGTH_RST      = 8'd16;
  localparam logic [7:0]  FRAMES_PER_SCROLL_RST = 8'd40;
  localparam logic [15:0] HOLD_TICKS_RST        = 16'd900;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TEXT_LENGTH       = 2'd0,
    REG_BLANK_LENGTH      = 2'd1,
    REG_FRAMES_PER_SCROLL = 2'd2,
    REG_HOLD_TICKS        = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_SHIFT = 3'b001,
    PH_LATCH = 3'b010,
    PH_HOLD  = 3'b100
  } phase_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       data;
  } fb_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
  } fb_rd_t;

  typedef struct packed {
    logic [1:0] row_address;
    logic       shift_strobe;
    logic       latch_pulse;
    logic       blank_display;
    logic [3:0] bit_idx;
  } stage_t;

endpackage

>>> hw/rtl/slms_if.sv
// Valid/ready channel interfaces for input items and panel pin results.
// No dependencies.
interface slms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] row_select;
  logic [7:0] column;
  logic [7:0] byte_value;

  modport source (output valid, command, row_select, column, byte_value, input ready);
  modport sink (input valid, command, row_select, column, byte_value, output ready);
endinterface

interface slms_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] row_address;
  logic       red_top;
  logic       red_bottom;
  logic       shift_strobe;
  logic       latch_pulse;
  logic       blank_display;

  modport source (output valid, row_address, red_top, red_bottom, shift_strobe,
                  latch_pulse, blank_display, input ready);
  modport sink (input valid, row_address, red_top, red_bottom, shift_strobe,
                latch_pulse, blank_display, output ready);
endinterface

>>> hw/rtl/slms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/slms_fbuf.sv
// Frame buffer: one RAM per panel row, column-wide valid bits for instant clear.
// Depends on slms_pkg and slms_ram.
module slms_fbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  slms_pkg::fb_wr_t wr,
  input  slms_pkg::fb_rd_t rd,
  output logic [7:0]       rd_data [slms_pkg::BUF_ROWS],
  output logic             rd_col_valid
);
  import slms_pkg::*;

  logic [BUF_COLS-1:0] col_valid;

  // A write into a cleared column zeroes the other rows of that column.
  for (genvar k = 0; k < BUF_ROWS; k++) begin : g_row
    logic       we;
    logic       hit;
    logic [7:0] wdata;

    assign hit   = (wr.row == ROW_W'(k));
    assign we    = wr.en && (hit || !col_valid[wr.col]);
    assign wdata = hit ? wr.data : 8'd0;

    slms_ram #(.WIDTH(8), .DEPTH(BUF_COLS)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wr.col),
      .wdata (wdata),
      .re    (rd.en),
      .raddr (rd.col),
      .rdata (rd_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_valid <= '0;
    end else if (wr.en) begin
      col_valid[wr.col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_col_valid <= col_valid[rd.col];
    end
  end

endmodule

>>> hw/rtl/scrolling_led_matrix_scan.sv
// Scan driver for a 1/4-scan LED panel with horizontal scrolling.
// A tick's pin state is registered in the buffer read and stage register when the tick
// is accepted, then in the result register, which holds while the result is not taken.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset (rst, synchronous): scan state and registers take their reset values and
// the frame buffer reads as zero at once; no clearing pass is needed.
// Depends on slms_pkg, slms_if, slms_fbuf.
module scrolling_led_matrix_scan (
  input  logic        clk,
  input  logic        rst,
  slms_in_if.sink     item,
  slms_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slms_pkg::*;

  // configuration
  logic [7:0]  text_length;
  logic [7:0]  blank_length;
  logic [7:0]  frames_per_scroll;
  logic [15:0] hold_ticks;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length       <= TEXT_LENGTH_RST;
      blank_length      <= BLANK_LENGTH_RST;
      frames_per_scroll <= FRAMES_PER_SCROLL_RST;
      hold_ticks        <= HOLD_TICKS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_TEXT_LENGTH:       text_length       <= pwdata[7:0];
        REG_BLANK_LENGTH:      blank_length      <= pwdata[7:0];
        REG_FRAMES_PER_SCROLL: frames_per_scroll <= pwdata[7:0];
        REG_HOLD_TICKS:        hold_ticks        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXT_LENGTH:       prdata = {24'd0, text_length};
      REG_BLANK_LENGTH:      prdata = {24'd0, blank_length};
      REG_FRAMES_PER_SCROLL: prdata = {24'd0, frames_per_scroll};
      REG_HOLD_TICKS:        prdata = {16'd0, hold_ticks};
      default:               prdata = 32'd0;
    endcase
  end

  // loop length, saturated at buffer width
  logic [LEN_W-1:0] len_sum;
  logic [LEN_W-1:0] loop_len;

  assign len_sum  = {1'b0, text_length} + {1'b0, blank_length};
  assign loop_len = (len_sum > LEN_W'(BUF_COLS)) ? LEN_W'(BUF_COLS) : len_sum;

  // pipeline handshake
  logic   s1_valid;
  stage_t s1;
  logic   s1_move;
  logic   accept;
  logic   tick;
  cmd_t   cmd;

  assign cmd        = cmd_t'(item.command);
  assign s1_move    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_move;
  assign accept     = item.valid && item.ready;
  assign tick       = accept && (cmd == CMD_TICK);

  // scan state
  logic [1:0]       scan_row,      scan_row_next;
  logic [CC_W-1:0]  column_count,  column_count_next;
  logic [7:0]       read_column,   read_column_next;
  logic [3:0]       bit_count,     bit_count_next;
  phase_t           scan_phase,    scan_phase_next;
  logic [15:0]      hold_count,    hold_count_next;
  logic [7:0]       frame_count,   frame_count_next;
  logic [7:0]       scroll_start,  scroll_start_next;

  logic [7:0]       rd_col;
  logic             end_row;
  logic [15:0]      hold_inc;
  logic [CC_W-1:0]  col_inc;
  logic [7:0]       frame_inc;
  logic [LEN_W-1:0] scroll_inc;
  logic [1:0]       row_inc;

  // column wraps at the first bit of each column
  assign rd_col = (bit_count == 4'd0 && {1'b0, read_column} >= loop_len) ? 8'd0
                                                                        : read_column;
  assign hold_inc   = hold_count + 16'd1;
  assign col_inc    = column_count + CC_W'(1);
  assign frame_inc  = frame_count + 8'd1;
  assign scroll_inc = {1'b0, scroll_start} + LEN_W'(1);
  assign row_inc    = scan_row + 2'd1;

  always_comb begin
    scan_row_next     = scan_row;
    column_count_next = column_count;
    read_column_next  = read_column;
    bit_count_next    = bit_count;
    scan_phase_next   = scan_phase;
    hold_count_next   = hold_count;
    frame_count_next  = frame_count;
    scroll_start_next = scroll_start;
    end_row           = 1'b0;

    unique case (scan_phase)
      PH_LATCH: begin
        if (hold_ticks == 16'd0) begin
          end_row = 1'b1;
        end else begin
          hold_count_next = 16'd0;
          scan_phase_next = PH_HOLD;
        end
      end
      PH_HOLD: begin
        hold_count_next = hold_inc;
        if (hold_inc >= hold_ticks || hold_inc == 16'd0) begin
          end_row = 1'b1;
        end
      end
      PH_SHIFT: begin
        if (bit_count == 4'd15) begin
          bit_count_next   = 4'd0;
          read_column_next = rd_col + 8'd1;
          if (col_inc == CC_W'(SHOWN_COLUMNS)) begin
            column_count_next = '0;
            scan_phase_next   = PH_LATCH;
          end else begin
            column_count_next = col_inc;
          end
        end else begin
          bit_count_next   = bit_count + 4'd1;
          read_column_next = rd_col;
        end
      end
      default: begin
        scan_phase_next = PH_SHIFT;
      end
    endcase

    if (end_row) begin
      scan_row_next = row_inc;
      if (row_inc == 2'd0) begin
        frame_count_next = frame_inc;
        if (frame_inc >= frames_per_scroll) begin
          frame_count_next  = 8'd0;
          scroll_start_next = (scroll_inc >= loop_len) ? 8'd0 : scroll_inc[7:0];
        end
      end
      read_column_next  = scroll_start_next;
      column_count_next = '0;
      bit_count_next    = 4'd0;
      hold_count_next   = 16'd0;
      scan_phase_next   = PH_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row     <= 2'd0;
      column_count <= '0;
      read_column  <= 8'd0;
      bit_count    <= 4'd0;
      scan_phase   <= PH_SHIFT;
      hold_count   <= 16'd0;
      frame_count  <= 8'd0;
      scroll_start <= 8'd0;
    end else if (tick) begin
      scan_row     <= scan_row_next;
      column_count <= column_count_next;
      read_column  <= read_column_next;
      bit_count    <= bit_count_next;
      scan_phase   <= scan_phase_next;
      hold_count   <= hold_count_next;
      frame_count  <= frame_count_next;
      scroll_start <= scroll_start_next;
    end
  end

  // frame buffer
  fb_wr_t     fb_wr;
  fb_rd_t     fb_rd;
  logic [7:0] rd_data [BUF_ROWS];
  logic       rd_col_valid;
  logic       fb_clear;

  assign fb_wr.en   = accept && (cmd == CMD_WRITE) &&
                      ({1'b0, item.column} < LEN_W'(BUF_COLS));
  assign fb_wr.row  = item.row_select[ROW_W-1:0];
  assign fb_wr.col  = item.column[COL_W-1:0];
  assign fb_wr.data = item.byte_value;
  assign fb_clear   = accept && (cmd == CMD_CLEAR);
  assign fb_rd.en   = tick && (scan_phase == PH_SHIFT);
  assign fb_rd.col  = rd_col[COL_W-1:0];

  slms_fbuf u_fbuf (
    .clk          (clk),
    .rst          (rst),
    .clear        (fb_clear),
    .wr           (fb_wr),
    .rd           (fb_rd),
    .rd_data      (rd_data),
    .rd_col_valid (rd_col_valid)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1.row_address   <= scan_row;
      s1.shift_strobe  <= (scan_phase == PH_SHIFT);
      s1.latch_pulse   <= (scan_phase == PH_LATCH);
      s1.blank_display <= (scan_phase != PH_HOLD);
      s1.bit_idx       <= bit_count;
    end
  end

  // first half: rows r+4 / r+12 MSB first; second half: rows r / r+8 LSB first
  logic [ROW_W-1:0] top_row;
  logic [ROW_W-1:0] bot_row;
  logic [2:0]       bit_pos;
  logic [7:0]       top_byte;
  logic [7:0]       bot_byte;
  logic             show;

  assign top_row  = {1'b0, ~s1.bit_idx[3], s1.row_address};
  assign bot_row  = {1'b1, ~s1.bit_idx[3], s1.row_address};
  assign bit_pos  = s1.bit_idx[3] ? s1.bit_idx[2:0] : ~s1.bit_idx[2:0];
  assign top_byte = rd_data[top_row];
  assign bot_byte = rd_data[bot_row];
  assign show     = s1.shift_strobe && rd_col_valid;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.row_address   <= s1.row_address;
      result.red_top       <= show && top_byte[bit_pos];
      result.red_bottom    <= show && bot_byte[bit_pos];
      result.shift_strobe  <= s1.shift_strobe;
      result.latch_pulse   <= s1.latch_pulse;
      result.blank_display <= s1.blank_display;
    end
  end

endmodule
